### rtl/core/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg
// Types, character codes and Morse look-up functions for the text codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtc_pkg;

	// character codes
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h5F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_NONE  = 8'h00;

	// token gathering limits
	localparam logic [2:0] SYM_CAP   = 3'd6;
	localparam logic [2:0] OVF_COUNT = 3'd7;

	// depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// one input transaction
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_line;
	} req_t;

	// one result transaction
	typedef struct packed {
		logic [7:0] out_byte;
		logic       bad_code;
		logic       last_of_run;
	} rsp_t;

	// work for the back end: symbols, then one byte, then an optional space
	typedef struct packed {
		logic [5:0] sym_bits;
		logic [2:0] sym_len;
		logic [7:0] first_byte;
		logic       first_bad;
		logic       has_second;
	} job_t;

	// push port of the job queue
	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	// result of a character look-up
	typedef struct packed {
		logic       found;
		logic [2:0] len;
		logic [5:0] bits;
	} code_t;

	// result of a token look-up
	typedef struct packed {
		logic       found;
		logic [7:0] ch;
	} char_t;

	// character to symbols, symbol i in bit i, dash is one
	function automatic code_t encode_lookup(input logic [7:0] key);
		code_t r;
		r = '{found: 1'b1, len: 3'd0, bits: 6'd0};
		unique case (key)
			"a": begin r.len = 3'd2; r.bits = 6'd2;  end
			"b": begin r.len = 3'd4; r.bits = 6'd1;  end
			"c": begin r.len = 3'd4; r.bits = 6'd5;  end
			"d": begin r.len = 3'd3; r.bits = 6'd1;  end
			"e": begin r.len = 3'd1; r.bits = 6'd0;  end
			"f": begin r.len = 3'd4; r.bits = 6'd4;  end
			"g": begin r.len = 3'd3; r.bits = 6'd3;  end
			"h": begin r.len = 3'd4; r.bits = 6'd0;  end
			"i": begin r.len = 3'd2; r.bits = 6'd0;  end
			"j": begin r.len = 3'd4; r.bits = 6'd14; end
			"k": begin r.len = 3'd3; r.bits = 6'd5;  end
			"l": begin r.len = 3'd4; r.bits = 6'd2;  end
			"m": begin r.len = 3'd2; r.bits = 6'd3;  end
			"n": begin r.len = 3'd2; r.bits = 6'd1;  end
			"o": begin r.len = 3'd3; r.bits = 6'd7;  end
			"p": begin r.len = 3'd4; r.bits = 6'd6;  end
			"q": begin r.len = 3'd4; r.bits = 6'd11; end
			"r": begin r.len = 3'd3; r.bits = 6'd2;  end
			"s": begin r.len = 3'd3; r.bits = 6'd0;  end
			"t": begin r.len = 3'd1; r.bits = 6'd1;  end
			"u": begin r.len = 3'd3; r.bits = 6'd4;  end
			"v": begin r.len = 3'd4; r.bits = 6'd8;  end
			"w": begin r.len = 3'd3; r.bits = 6'd6;  end
			"x": begin r.len = 3'd4; r.bits = 6'd9;  end
			"y": begin r.len = 3'd4; r.bits = 6'd13; end
			"z": begin r.len = 3'd4; r.bits = 6'd3;  end
			"0": begin r.len = 3'd5; r.bits = 6'd31; end
			"1": begin r.len = 3'd5; r.bits = 6'd30; end
			"2": begin r.len = 3'd5; r.bits = 6'd28; end
			"3": begin r.len = 3'd5; r.bits = 6'd24; end
			"4": begin r.len = 3'd5; r.bits = 6'd16; end
			"5": begin r.len = 3'd5; r.bits = 6'd0;  end
			"6": begin r.len = 3'd5; r.bits = 6'd1;  end
			"7": begin r.len = 3'd5; r.bits = 6'd3;  end
			"8": begin r.len = 3'd5; r.bits = 6'd7;  end
			"9": begin r.len = 3'd5; r.bits = 6'd15; end
			".": begin r.len = 3'd6; r.bits = 6'd42; end
			":": begin r.len = 3'd6; r.bits = 6'd7;  end
			";": begin r.len = 3'd6; r.bits = 6'd21; end
			"?": begin r.len = 3'd6; r.bits = 6'd12; end
			"=": begin r.len = 3'd5; r.bits = 6'd17; end
			"/": begin r.len = 3'd5; r.bits = 6'd9;  end
			"!": begin r.len = 3'd6; r.bits = 6'd53; end
			"-": begin r.len = 3'd6; r.bits = 6'd33; end
			"+": begin r.len = 3'd5; r.bits = 6'd10; end
			"&": begin r.len = 3'd5; r.bits = 6'd2;  end
			"(": begin r.len = 3'd5; r.bits = 6'd13; end
			")": begin r.len = 3'd6; r.bits = 6'd45; end
			default: r.found = 1'b0;
		endcase
		return r;
	endfunction

	// symbols to lowercase character
	function automatic char_t decode_lookup(input logic [2:0] len, input logic [5:0] bits);
		char_t r;
		r = '{found: 1'b1, ch: CH_NONE};
		unique case ({len, bits})
			{3'd2, 6'd2}:  r.ch = "a";
			{3'd4, 6'd1}:  r.ch = "b";
			{3'd4, 6'd5}:  r.ch = "c";
			{3'd3, 6'd1}:  r.ch = "d";
			{3'd1, 6'd0}:  r.ch = "e";
			{3'd4, 6'd4}:  r.ch = "f";
			{3'd3, 6'd3}:  r.ch = "g";
			{3'd4, 6'd0}:  r.ch = "h";
			{3'd2, 6'd0}:  r.ch = "i";
			{3'd4, 6'd14}: r.ch = "j";
			{3'd3, 6'd5}:  r.ch = "k";
			{3'd4, 6'd2}:  r.ch = "l";
			{3'd2, 6'd3}:  r.ch = "m";
			{3'd2, 6'd1}:  r.ch = "n";
			{3'd3, 6'd7}:  r.ch = "o";
			{3'd4, 6'd6}:  r.ch = "p";
			{3'd4, 6'd11}: r.ch = "q";
			{3'd3, 6'd2}:  r.ch = "r";
			{3'd3, 6'd0}:  r.ch = "s";
			{3'd1, 6'd1}:  r.ch = "t";
			{3'd3, 6'd4}:  r.ch = "u";
			{3'd4, 6'd8}:  r.ch = "v";
			{3'd3, 6'd6}:  r.ch = "w";
			{3'd4, 6'd9}:  r.ch = "x";
			{3'd4, 6'd13}: r.ch = "y";
			{3'd4, 6'd3}:  r.ch = "z";
			{3'd5, 6'd31}: r.ch = "0";
			{3'd5, 6'd30}: r.ch = "1";
			{3'd5, 6'd28}: r.ch = "2";
			{3'd5, 6'd24}: r.ch = "3";
			{3'd5, 6'd16}: r.ch = "4";
			{3'd5, 6'd0}:  r.ch = "5";
			{3'd5, 6'd1}:  r.ch = "6";
			{3'd5, 6'd3}:  r.ch = "7";
			{3'd5, 6'd7}:  r.ch = "8";
			{3'd5, 6'd15}: r.ch = "9";
			{3'd6, 6'd42}: r.ch = ".";
			{3'd6, 6'd7}:  r.ch = ":";
			{3'd6, 6'd21}: r.ch = ";";
			{3'd6, 6'd12}: r.ch = "?";
			{3'd5, 6'd17}: r.ch = "=";
			{3'd5, 6'd9}:  r.ch = "/";
			{3'd6, 6'd53}: r.ch = "!";
			{3'd6, 6'd33}: r.ch = "-";
			{3'd5, 6'd10}: r.ch = "+";
			{3'd5, 6'd2}:  r.ch = "&";
			{3'd5, 6'd13}: r.ch = "(";
			{3'd6, 6'd45}: r.ch = ")";
			default:       r.found = 1'b0;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/mtc_front.sv
// ----------------------------------------------------------------------------
// mtc_front
// Accepts text bytes, tracks line direction and token, and turns bytes
// into jobs for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mtc_pkg::req_t  req,
	input  logic           q_full,
	output mtc_pkg::push_t q_push
);

	logic       line_start_q;
	logic       decode_q;
	logic [5:0] bits_q;
	logic [2:0] cnt_q;

	logic             accept;
	logic [7:0]       c;
	logic             is_sym;
	logic             is_sep;
	logic             mode_eff;
	logic [5:0]       bits_eff;
	logic [2:0]       cnt_eff;
	logic [5:0]       bits_new;
	logic [2:0]       cnt_new;
	logic [5:0]       fl_bits;
	logic [2:0]       fl_cnt;
	logic             fl_has;
	logic             fl_bad;
	logic [7:0]       fl_byte;
	logic [7:0]       key;
	mtc_pkg::code_t   enc;
	mtc_pkg::char_t   dec;
	mtc_pkg::job_t    job;
	logic             job_any;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;
	assign c         = req.in_byte;
	assign is_sym    = (c == mtc_pkg::CH_DOT) || (c == mtc_pkg::CH_DASH);
	assign is_sep    = (c == mtc_pkg::CH_SPACE) || (c == mtc_pkg::CH_SLASH);

	// direction and token as seen by this byte
	assign mode_eff = line_start_q ? is_sym : decode_q;
	assign bits_eff = line_start_q ? 6'd0 : bits_q;
	assign cnt_eff  = line_start_q ? 3'd0 : cnt_q;

	// gather one symbol into the token
	always_comb begin
		bits_new = bits_eff;
		cnt_new  = cnt_eff;
		if (cnt_eff != mtc_pkg::OVF_COUNT) begin
			if (!is_sym || cnt_eff >= mtc_pkg::SYM_CAP) begin
				cnt_new = mtc_pkg::OVF_COUNT;
			end else begin
				bits_new = bits_eff | (6'((c == mtc_pkg::CH_DASH)) << cnt_eff);
				cnt_new  = cnt_eff + 3'd1;
			end
		end
	end

	// token to flush: the old one at a separator, the grown one at end of line
	assign fl_bits = is_sep ? bits_eff : bits_new;
	assign fl_cnt  = is_sep ? cnt_eff : cnt_new;
	assign dec     = mtc_pkg::decode_lookup(fl_cnt, fl_bits);
	assign fl_has  = (fl_cnt != 3'd0) && (is_sep || req.end_of_line);
	assign fl_bad  = (fl_cnt == mtc_pkg::OVF_COUNT) || !dec.found;
	assign fl_byte = fl_bad ? mtc_pkg::CH_NONE : dec.ch;

	// character look-up for encoding, either case
	assign key = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
	assign enc = mtc_pkg::encode_lookup(key);

	// build the job
	always_comb begin
		job     = '0;
		job_any = 1'b1;
		if (!mode_eff) begin
			if (c == mtc_pkg::CH_SPACE) begin
				job.first_byte = mtc_pkg::CH_SLASH;
			end else if (enc.found) begin
				job.sym_bits   = enc.bits;
				job.sym_len    = enc.len;
				job.first_byte = mtc_pkg::CH_SPACE;
			end else begin
				job.first_byte = mtc_pkg::CH_NONE;
				job.first_bad  = 1'b1;
			end
		end else if (fl_has) begin
			job.first_byte = fl_byte;
			job.first_bad  = fl_bad;
			job.has_second = (c == mtc_pkg::CH_SPACE);
		end else if (c == mtc_pkg::CH_SPACE) begin
			job.first_byte = mtc_pkg::CH_SPACE;
		end else begin
			job_any = 1'b0;
		end
	end

	assign q_push.push = accept && job_any;
	assign q_push.job  = job;

	// line and token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q <= 1'b1;
			decode_q     <= 1'b0;
			bits_q       <= '0;
			cnt_q        <= '0;
		end else if (accept) begin
			decode_q <= mode_eff;
			if (req.end_of_line) begin
				line_start_q <= 1'b1;
				bits_q       <= '0;
				cnt_q        <= '0;
			end else begin
				line_start_q <= 1'b0;
				if (!mode_eff || is_sep) begin
					bits_q <= '0;
					cnt_q  <= '0;
				end else begin
					bits_q <= bits_new;
					cnt_q  <= cnt_new;
				end
			end
		end
	end

	// checks
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.push |-> !q_full)
		else $error("job pushed into a full queue");
	a_ovf_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(!line_start_q && cnt_q != mtc_pkg::OVF_COUNT) |-> ((bits_q >> cnt_q) == 6'd0))
		else $error("token holds symbol bits beyond its length");
	a_line_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		line_start_q |-> (cnt_q == 3'd0 || $past(!arst_n)))
		else $error("token not cleared at line start");

endmodule

### rtl/core/mtc_queue.sv
// ----------------------------------------------------------------------------
// mtc_queue
// Short job queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  mtc_pkg::push_t q_push,
	output logic           full,
	output logic           avail,
	output mtc_pkg::job_t  head,
	input  logic           pop
);

	localparam int PW = (mtc_pkg::QUEUE_DEPTH > 1) ? $clog2(mtc_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(mtc_pkg::QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(mtc_pkg::QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_C  = PW'(mtc_pkg::QUEUE_DEPTH - 1);

	mtc_pkg::job_t   slot_q [mtc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == DEPTH_C);
	assign avail = (cnt_q != '0);
	assign head  = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (q_push.push) begin
			slot_q[wr_q] <= q_push.job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (q_push.push) begin
				wr_q <= (wr_q == LAST_C) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_C) ? '0 : rd_q + PW'(1);
			end
			case ({q_push.push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// checks
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail)
		else $error("job popped from an empty queue");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("queue level beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("empty queue with pointers apart");

endmodule

### rtl/core/mtc_back.sv
// ----------------------------------------------------------------------------
// mtc_back
// Expands jobs into result bytes, one per cycle unless rsp stalls, through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          avail,
	input  mtc_pkg::job_t head,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mtc_pkg::rsp_t rsp
);

	mtc_pkg::job_t job_q;
	logic          busy_q;
	logic [2:0]    step_q;
	logic          out_valid_q;
	mtc_pkg::rsp_t out_q;

	logic          adv;
	logic          last;
	logic [5:0]    sym_sh;
	mtc_pkg::rsp_t cur;

	assign adv    = !out_valid_q || !rsp_stall;
	assign sym_sh = job_q.sym_bits >> step_q;

	// current result byte of the job
	always_comb begin
		cur  = '0;
		last = 1'b0;
		if (step_q < job_q.sym_len) begin
			cur.out_byte = sym_sh[0] ? mtc_pkg::CH_DASH : mtc_pkg::CH_DOT;
		end else if (step_q == job_q.sym_len) begin
			cur.out_byte = job_q.first_byte;
			cur.bad_code = job_q.first_bad;
			last         = !job_q.has_second;
		end else begin
			cur.out_byte = mtc_pkg::CH_SPACE;
			last         = 1'b1;
		end
		cur.last_of_run = last;
	end

	assign pop = avail && (!busy_q || (adv && last));

	// job sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q && adv) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			out_q <= cur;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// checks
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q <= job_q.sym_len + 3'd1))
		else $error("job step past its last byte");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.bad_code) |-> (rsp.out_byte == mtc_pkg::CH_NONE))
		else $error("error result carries a byte");
	a_symbol_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.out_byte == mtc_pkg::CH_DASH || rsp.out_byte == mtc_pkg::CH_DOT)
			&& $past(busy_q && adv && step_q < job_q.sym_len)) |-> !rsp.last_of_run)
		else $error("symbol byte marked as last of run");

endmodule

### rtl/core/morse_text_codec.sv
// ----------------------------------------------------------------------------
// morse_text_codec
// International Morse text codec: text to dots and dashes, and back.
// ----------------------------------------------------------------------------
// channel   handshake             payload   carries
// req       req_valid/req_stall   req_t     in_byte, end_of_line
// rsp       rsp_valid/rsp_stall   rsp_t     out_byte, bad_code, last_of_run
//
// One result byte leaves per cycle unless rsp stalls; the back end's byte sequencer sets this.
// An item causes 1 to 7 result bytes when encoding,
// 0 to 2 when decoding; an item causing no result pushes no job.
// A two-entry job queue lets the front take items while results drain.
// Reset clears line state, queue and output valid; no clearing pass.
// A stall on rsp holds the result and, once the queue fills, stalls req.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module morse_text_codec (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mtc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mtc_pkg::rsp_t rsp
);

	mtc_pkg::push_t q_push;
	mtc_pkg::job_t  head;
	logic           q_full;
	logic           q_avail;
	logic           q_pop;

	// classify incoming bytes
	mtc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push)
	);

	// job queue
	mtc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.full   (q_full),
		.avail  (q_avail),
		.head   (head),
		.pop    (q_pop)
	);

	// expand jobs into result bytes
	mtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (q_avail),
		.head      (head),
		.pop       (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
